FILE: hw/rtl/tap_tempo_bpm_estimator_core_defines.svh
// Assertion macros shared by the tap tempo estimator RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef TAP_TEMPO_BPM_ESTIMATOR_CORE_DEFINES_SVH
`define TAP_TEMPO_BPM_ESTIMATOR_CORE_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define TTB_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TTB_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/ttb_pkg.sv
// Types, constants and sequencer states for the tap tempo estimator.
// Depends on nothing; imported by every RTL module of the block.
package ttb_pkg;

    localparam int TIME_W     = 43;       // seconds * 1000 + millis
    localparam int SUB_W      = 44;       // shared subtractor width
    localparam int NUM_W      = 36;       // 600000 * 65535 fits in 36 bits
    localparam int DIV_STEPS  = NUM_W;    // one quotient bit per step
    localparam int STEP_W     = 6;
    localparam int CNT_W      = 16;
    localparam int TEMPO_W    = 16;

    localparam int unsigned TEMPO_NUM   = 600000;
    localparam int unsigned MS_PER_SEC  = 1000;
    localparam logic [7:0]  TIMEOUT_RST = 8'd2;

    typedef struct packed {
        logic [31:0] stamp_seconds;
        logic [9:0]  stamp_millis;
    } in_item_t;

    typedef struct packed {
        logic [15:0] tempo_tenths;
        logic        restarted;
        logic [15:0] taps_counted;
    } out_item_t;

    typedef struct packed {
        logic start;     // input transaction accepted this cycle
        logic out_free;  // output register can take a result
    } eng_ctrl_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_stat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GAP_FWD,
        ST_GAP_REV,
        ST_CMP,
        ST_ELP_FWD,
        ST_ELP_REV,
        ST_DIV,
        ST_TEMPO,
        ST_DONE
    } state_t;

endpackage

FILE: hw/rtl/ttb_sub.sv
// Shared subtractor of the tap tempo estimator: difference and borrow.
// Depends on ttb_pkg for the operand width.
module ttb_sub (
    input  logic [ttb_pkg::SUB_W-1:0] a,
    input  logic [ttb_pkg::SUB_W-1:0] b,
    output logic [ttb_pkg::SUB_W-1:0] diff,
    output logic                      borrow
);
    import ttb_pkg::*;

    logic [SUB_W:0] wide;

    assign wide   = {1'b0, a} - {1'b0, b};
    assign diff   = wide[SUB_W-1:0];
    assign borrow = wide[SUB_W];

endmodule

FILE: hw/rtl/ttb_engine.sv
// Sequencer and tap state of the tap tempo estimator: gap test, elapsed time
// and a restoring divider, all on one shared subtractor (ttb_sub, ttb_pkg).
`include "tap_tempo_bpm_estimator_core_defines.svh"

module ttb_engine (
    input  logic               aclk,
    input  logic               aresetn,
    input  ttb_pkg::in_item_t  in_item,
    input  logic [7:0]         timeout_seconds,
    input  ttb_pkg::eng_ctrl_t ctrl,
    output ttb_pkg::eng_stat_t stat,
    output ttb_pkg::out_item_t result
);
    import ttb_pkg::*;

    state_t              state_reg, state_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   last_reg, last_next;
    logic [TIME_W-1:0]   first_reg, first_next;
    logic [TIME_W-1:0]   gap_reg, gap_next;
    logic                run_started_reg, run_started_next;
    logic                restart_reg, restart_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [TEMPO_W-1:0]  tempo_reg, tempo_next;
    logic [NUM_W-1:0]    num_reg, num_next;
    logic [SUB_W-1:0]    rem_reg, rem_next;
    logic [NUM_W-1:0]    quo_reg, quo_next;
    logic [STEP_W-1:0]   step_reg, step_next;

    logic [SUB_W-1:0]    sub_a, sub_b, sub_diff;
    logic                sub_borrow;
    logic [SUB_W-1:0]    rem_shift;

    ttb_sub u_sub (
        .a      (sub_a),
        .b      (sub_b),
        .diff   (sub_diff),
        .borrow (sub_borrow)
    );

    assign rem_shift = {rem_reg[SUB_W-2:0], num_reg[NUM_W-1]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            run_started_reg <= 1'b0;
            count_reg       <= '0;
            tempo_reg       <= '0;
            first_reg       <= '0;
            last_reg        <= '0;
            restart_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            run_started_reg <= run_started_next;
            count_reg       <= count_next;
            tempo_reg       <= tempo_next;
            first_reg       <= first_next;
            last_reg        <= last_next;
            restart_reg     <= restart_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg  <= now_next;
        gap_reg  <= gap_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        quo_reg  <= quo_next;
        step_reg <= step_next;
    end

    always_comb begin
        state_next       = state_reg;
        now_next         = now_reg;
        last_next        = last_reg;
        first_next       = first_reg;
        gap_next         = gap_reg;
        run_started_next = run_started_reg;
        restart_next     = restart_reg;
        count_next       = count_reg;
        tempo_next       = tempo_reg;
        num_next         = num_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        sub_a            = '0;
        sub_b            = '0;
        stat.idle        = 1'b0;
        stat.done        = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                stat.idle = 1'b1;
                if (ctrl.start) begin
                    now_next   = TIME_W'(in_item.stamp_seconds) * TIME_W'(MS_PER_SEC)
                               + TIME_W'(in_item.stamp_millis);
                    state_next = ST_GAP_FWD;
                end
            end
            ST_GAP_FWD: begin
                sub_a    = SUB_W'(now_reg);
                sub_b    = SUB_W'(last_reg);
                gap_next = sub_diff[TIME_W-1:0];
                state_next = sub_borrow ? ST_GAP_REV : ST_CMP;
            end
            ST_GAP_REV: begin
                sub_a      = SUB_W'(last_reg);
                sub_b      = SUB_W'(now_reg);
                gap_next   = sub_diff[TIME_W-1:0];
                state_next = ST_CMP;
            end
            ST_CMP: begin
                // whole-second gap >= timeout  <=>  gap_ms >= timeout * 1000
                sub_a     = SUB_W'(gap_reg);
                sub_b     = SUB_W'(timeout_seconds) * SUB_W'(MS_PER_SEC);
                last_next = now_reg;
                if (!run_started_reg || !sub_borrow) begin
                    restart_next     = 1'b1;
                    run_started_next = 1'b1;
                    first_next       = now_reg;
                    count_next       = '0;
                    tempo_next       = '0;
                    state_next       = ST_DONE;
                end else begin
                    restart_next = 1'b0;
                    if (count_reg != {CNT_W{1'b1}}) begin
                        count_next = count_reg + CNT_W'(1);
                    end
                    state_next = ST_ELP_FWD;
                end
            end
            ST_ELP_FWD: begin
                sub_a      = SUB_W'(now_reg);
                sub_b      = SUB_W'(first_reg);
                gap_next   = sub_diff[TIME_W-1:0];
                num_next   = NUM_W'(count_reg) * NUM_W'(TEMPO_NUM);
                rem_next   = '0;
                step_next  = '0;
                state_next = sub_borrow ? ST_ELP_REV : ST_DIV;
            end
            ST_ELP_REV: begin
                sub_a      = SUB_W'(first_reg);
                sub_b      = SUB_W'(now_reg);
                gap_next   = sub_diff[TIME_W-1:0];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // restoring step; a zero divisor never borrows, so the
                // quotient comes out all ones and saturates below
                sub_a    = rem_shift;
                sub_b    = SUB_W'(gap_reg);
                rem_next = sub_borrow ? rem_shift : sub_diff;
                quo_next = {quo_reg[NUM_W-2:0], ~sub_borrow};
                num_next = {num_reg[NUM_W-2:0], 1'b0};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DIV_STEPS - 1)) begin
                    state_next = ST_TEMPO;
                end
            end
            ST_TEMPO: begin
                tempo_next = (|quo_reg[NUM_W-1:TEMPO_W]) ? {TEMPO_W{1'b1}}
                                                         : quo_reg[TEMPO_W-1:0];
                state_next = ST_DONE;
            end
            ST_DONE: begin
                stat.done = 1'b1;
                if (ctrl.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign result.tempo_tenths = tempo_reg;
    assign result.restarted    = restart_reg;
    assign result.taps_counted = count_reg;

    `TTB_ASSERT_NOW(a_start_only_idle, aclk, aresetn, ctrl.start, state_reg == ST_IDLE, "start outside idle")
    `TTB_ASSERT_NEXT(a_done_to_idle, aclk, aresetn, stat.done && ctrl.out_free, state_reg == ST_IDLE, "done not retired")
    `TTB_ASSERT_NOW(a_restart_zero, aclk, aresetn, stat.done && restart_reg, tempo_reg == '0 && count_reg == '0, "restart result not cleared")
    `TTB_ASSERT_NOW(a_run_count, aclk, aresetn, stat.done && !restart_reg, count_reg != '0 && run_started_reg, "run result with zero count")

endmodule

FILE: hw/rtl/tap_tempo_bpm_estimator_core.sv
// Tap tempo estimator top level: handshakes, timeout register, result register.
// A restarting tap runs only the gap test before its result; a tap inside a run also
// computes the elapsed time and runs a 36-step restoring divide on the shared subtractor.
// A tap is taken only once the sequencer is back in idle; a new tap is taken while a result waits.
// Reset (aresetn low, synchronous) clears the run, count and tempo; timeout returns to 2.
// Depends on ttb_pkg, ttb_engine and ttb_sub.
module tap_tempo_bpm_estimator_core (
    input  logic               aclk,
    input  logic               aresetn,
    // tap input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  ttb_pkg::in_item_t  s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output ttb_pkg::out_item_t m_data,
    // timeout register write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_data
);
    import ttb_pkg::*;

    logic [7:0] timeout_reg, timeout_next;
    logic       out_valid_reg, out_valid_next;
    out_item_t  out_data_reg, out_data_next;

    eng_ctrl_t  eng_ctrl;
    eng_stat_t  eng_stat;
    out_item_t  eng_result;

    // The register accepts a write in any cycle; the user must write only while idle, which the block does not enforce.
    assign cfg_ready = 1'b1;

    // Take a tap whenever the sequencer sits in idle, even with a result
    // still parked in the output register.
    assign s_ready = eng_stat.idle;

    // The output register frees up when empty or drained this cycle.
    assign eng_ctrl.start    = s_valid && s_ready;
    assign eng_ctrl.out_free = !out_valid_reg || m_ready;

    ttb_engine u_engine (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_item         (s_data),
        .timeout_seconds (timeout_reg),
        .ctrl            (eng_ctrl),
        .stat            (eng_stat),
        .result          (eng_result)
    );

    always_comb begin
        timeout_next   = timeout_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (cfg_valid && cfg_ready) begin
            timeout_next = cfg_data;
        end

        // Drop the transaction once taken, then load a finished result.
        if (m_valid && m_ready) begin
            out_valid_next = 1'b0;
        end
        if (eng_stat.done && eng_ctrl.out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = eng_result;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg   <= TIMEOUT_RST;
            out_valid_reg <= 1'b0;
        end else begin
            timeout_reg   <= timeout_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload register: hold while the transaction waits.
    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

FILE: tb/tap_tempo_bpm_estimator_core_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for tap_tempo_bpm_estimator_core: tap traffic in, tempo results out.
// Depends on ttb_pkg for the payload structs and on the core RTL; needs no other files.

module tap_tempo_bpm_estimator_core_test;
    import ttb_pkg::*;

    localparam logic [63:0] MS_PER_SECOND   = 64'd1000;
    localparam logic [63:0] TEMPO_SCALE     = 64'd600000;  // tenths of BPM times ms per beat
    localparam logic [63:0] STAMP_SPAN_MS   = 64'd4294967296000;
    localparam int          STALL_LIMIT     = 4000;  // cycles without any transaction
    localparam int          DRAIN_CYCLES    = 60;    // a little over the longest tap latency
    localparam int          PRESSURE_CYCLES = 400;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_valid   = 1'b0;
    logic       s_ready;
    in_item_t   s_data    = '0;
    logic       m_valid;
    logic       m_ready   = 1'b0;
    out_item_t  m_data;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data  = 8'd0;

    tap_tempo_bpm_estimator_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Taps waiting to be offered, and tempo readings the core still owes us.
    in_item_t    taps_to_send[$];
    out_item_t   pending_readings[$];

    // Shadow of the core's measurement state and timeout register.
    logic        run_on    = 1'b0;
    logic [63:0] first_ms  = '0;
    logic [63:0] last_ms   = '0;
    logic [15:0] tap_count = '0;
    logic [15:0] tempo_now = '0;
    logic [7:0]  timeout_s = TIMEOUT_RST;

    int          send_idle_pct    = 0;
    int          recv_idle_pct    = 0;
    int          hold_left        = 0;
    int          quiet_cycles     = 0;
    int          mismatch_count   = 0;
    int          taps_accepted    = 0;
    int          readings_checked = 0;
    logic [63:0] gen_ms           = '0;

    task automatic report_error(input string msg);
        $display("ERROR at %0t ns: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic logic [63:0] ms_span(input logic [63:0] a, input logic [63:0] b);
        return (a >= b) ? a - b : b - a;
    endfunction

    // Advance the shadow state by one tap and return the reading it should produce.
    function automatic out_item_t estimate_tempo(input in_item_t tap);
        logic [63:0] now_ms;
        logic [63:0] elapsed;
        logic [63:0] quotient;
        logic        restart;
        out_item_t   reading;
        now_ms  = 64'(tap.stamp_seconds) * MS_PER_SECOND + 64'(tap.stamp_millis);
        // Whole-second gap, rounded down, against the timeout; no run yet forces a restart.
        restart = !run_on || (ms_span(now_ms, last_ms) / MS_PER_SECOND >= 64'(timeout_s));
        if (restart) begin
            run_on    = 1'b1;
            first_ms  = now_ms;
            tap_count = '0;
            tempo_now = '0;
        end else begin
            if (tap_count != 16'hFFFF) begin
                tap_count++;
            end
            elapsed = ms_span(now_ms, first_ms);
            if (elapsed == 0) begin
                tempo_now = 16'hFFFF;
            end else begin
                quotient  = (TEMPO_SCALE * 64'(tap_count)) / elapsed;
                tempo_now = (quotient > 64'hFFFF) ? 16'hFFFF : quotient[15:0];
            end
        end
        last_ms = now_ms;
        reading.tempo_tenths = tempo_now;
        reading.restarted    = restart;
        reading.taps_counted = tap_count;
        return reading;
    endfunction

    task automatic queue_tap(input logic [31:0] seconds, input logic [9:0] millis);
        in_item_t tap;
        tap.stamp_seconds = seconds;
        tap.stamp_millis  = millis;
        taps_to_send.push_back(tap);
    endtask

    // Mostly plausible tap trains under the current timeout, with backward steps,
    // steps around the timeout boundary, unnormalized millis and wild jumps mixed in.
    task automatic add_random_taps(input int count);
        int unsigned pick;
        logic [63:0] limit_ms;
        logic [63:0] step;
        in_item_t    tap;
        limit_ms = 64'(timeout_s) * MS_PER_SECOND;
        repeat (count) begin
            pick = $urandom_range(99);
            if (pick < 8) begin
                tap.stamp_seconds = $urandom;
                tap.stamp_millis  = 10'($urandom_range(1023));
            end else if (pick < 13) begin
                tap.stamp_seconds = 32'(gen_ms / MS_PER_SECOND);
                tap.stamp_millis  = 10'(1000 + $urandom_range(23));
            end else begin
                if (pick < 23) begin
                    step = limit_ms + $urandom_range(4000);
                end else if ($urandom_range(4) == 0) begin
                    step = $urandom_range(32'(limit_ms) + 999);
                end else begin
                    step = $urandom_range(1500);
                end
                if (pick >= 23 && pick < 36) begin
                    gen_ms = (step > gen_ms) ? 64'd0 : gen_ms - step;
                end else begin
                    gen_ms = (gen_ms + step) % STAMP_SPAN_MS;
                end
                tap.stamp_seconds = 32'(gen_ms / MS_PER_SECOND);
                tap.stamp_millis  = 10'(gen_ms % MS_PER_SECOND);
            end
            gen_ms = (64'(tap.stamp_seconds) * MS_PER_SECOND + 64'(tap.stamp_millis))
                     % STAMP_SPAN_MS;
            taps_to_send.push_back(tap);
        end
    endtask

    // Return at a rising edge once every tap is in and every reading is out.
    task automatic wait_idle();
        do begin
            @(posedge aclk);
        end while (taps_to_send.size() != 0 || s_valid || pending_readings.size() != 0);
    endtask

    // Call at a rising edge with the core idle; hold the write until it is taken.
    task automatic set_timeout(input logic [7:0] seconds);
        cfg_valid <= 1'b1;
        cfg_data  <= seconds;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid <= 1'b0;
        timeout_s = seconds;
    endtask

    // Tap driver: predict on every accepted transaction, then offer the next tap
    // unless the sender idles this cycle. Valid holds until the tap is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pending_readings.push_back(estimate_tempo(s_data));
                taps_accepted++;
            end
            if (!s_valid || s_ready) begin
                if (taps_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_data  <= taps_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted reading against the oldest prediction.
    // Twice in the run, drop ready for a long stretch so the core backs up into its input.
    always @(posedge aclk) begin
        out_item_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_readings.size() == 0) begin
                    report_error($sformatf("reading with no tap pending: tempo %0d",
                                           m_data.tempo_tenths));
                end else begin
                    want = pending_readings.pop_front();
                    if (m_data.tempo_tenths !== want.tempo_tenths) begin
                        report_error($sformatf("tempo_tenths got %0d, expected %0d",
                                               m_data.tempo_tenths, want.tempo_tenths));
                    end
                    if (m_data.restarted !== want.restarted) begin
                        report_error($sformatf("restarted got %0b, expected %0b",
                                               m_data.restarted, want.restarted));
                    end
                    if (m_data.taps_counted !== want.taps_counted) begin
                        report_error($sformatf("taps_counted got %0d, expected %0d",
                                               m_data.taps_counted, want.taps_counted));
                    end
                end
                readings_checked++;
                if (readings_checked == 150 || readings_checked == 700) begin
                    hold_left = PRESSURE_CYCLES;
                end
            end
            if (hold_left != 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Watchdog: end the run if no channel moves a transaction for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)
                || (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("Watchdog expired: %0d cycles without a transaction, %0d readings owed",
                         STALL_LIMIT, pending_readings.size());
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed taps under the reset timeout of 2 s.
        send_idle_pct = 30;
        recv_idle_pct = 71;
        queue_tap(32'd0, 10'd0);             // first tap ever: opens a run
        queue_tap(32'd0, 10'd0);             // same instant: zero elapsed, max tempo
        queue_tap(32'd0, 10'd1);             // 1 ms elapsed: tempo saturates
        queue_tap(32'd0, 10'd500);
        queue_tap(32'd1, 10'd1023);          // millis past 999 taken as is
        queue_tap(32'd0, 10'd999);           // earlier than the last tap
        queue_tap(32'd2, 10'd999);           // gap of exactly 2 s: restart
        queue_tap(32'd4, 10'd998);           // gap just under 2 s: stays in the run
        queue_tap(32'd4, 10'd997);
        queue_tap(32'd2, 10'd998);           // earlier than the first tap of the run
        queue_tap(32'hFFFF_FFFF, 10'd999);   // far jump: restart at the top of the range
        queue_tap(32'hFFFF_FFFF, 10'd1023);
        queue_tap(32'hFFFF_FFFE, 10'd0);     // 2023 ms back: restart
        queue_tap(32'hFFFF_FFFE, 10'd1);
        queue_tap(32'hFFFF_FFFF, 10'd999);
        queue_tap(32'd0, 10'd0);             // huge backward gap: restart
        queue_tap(32'd1, 10'd999);           // slow tempo
        queue_tap(32'd3, 10'd998);
        queue_tap(32'd5, 10'd997);
        queue_tap(32'hAAAA_AAAA, 10'h2AA);
        queue_tap(32'h5555_5555, 10'h155);
        queue_tap(32'h5555_5555, 10'h156);
        wait_idle();

        // Random phases; the timeouts of 1 and 255 come first.
        set_timeout(8'd1);
        add_random_taps(250);
        wait_idle();
        set_timeout(8'd255);
        add_random_taps(250);
        wait_idle();

        // Swap the idling: sender mostly idle, receiver mostly ready.
        send_idle_pct = 71;
        recv_idle_pct = 30;
        set_timeout(8'd0);                   // every gap meets a zero timeout
        add_random_taps(60);
        wait_idle();
        set_timeout(8'($urandom_range(3, 40)));
        add_random_taps(250);
        wait_idle();

        // Full speed on both sides.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_timeout(TIMEOUT_RST);
        add_random_taps(200);
        wait_idle();
        set_timeout(8'($urandom_range(1, 255)));
        add_random_taps(200);
        wait_idle();

        // Give a stray late reading time to show up.
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered timeouts 0, 1, 2, 255 and two random values under three idle mixes.");
        $display("Taps accepted: %0d, readings checked: %0d, errors: %0d",
                 taps_accepted, readings_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

FILE: tap_tempo_bpm_estimator_core.f
+incdir+hw/rtl
hw/rtl/ttb_pkg.sv
hw/rtl/ttb_sub.sv
hw/rtl/ttb_engine.sv
hw/rtl/tap_tempo_bpm_estimator_core.sv
tb/tap_tempo_bpm_estimator_core_test.sv
